[rtl/core/pkwrl_pkg.sv]
`timescale 1ns / 1ps
// package: shared constants, types and codes of the per-key window rate limiter
package pkwrl_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;

    localparam int KEY_W    = 32;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int LIMIT_W  = 8;
    localparam int WINDOW_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int OUTCOME_W  = 3;

    localparam logic [LIMIT_W-1:0]  RESET_LIMIT  = 8'd10;
    localparam logic [WINDOW_W-1:0] RESET_WINDOW = 16'd60;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd1;

    // result codes
    localparam logic [OUTCOME_W-1:0] OUT_COUNTED  = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_RESTART  = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_NEW      = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_REPLACED = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_REFUSED  = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  start;
    } t_entry;

    typedef struct packed {
        logic                 allowed;
        logic [OUTCOME_W-1:0] outcome;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

endpackage

[rtl/core/pkwrl_if.sv]
`timescale 1ns / 1ps
// interfaces: request and response channels with valid/ready handshake
interface pkwrl_req_if;
    logic                        valid;
    logic                        ready;
    logic [pkwrl_pkg::KEY_W-1:0]  key_id;
    logic [pkwrl_pkg::TIME_W-1:0] now_seconds;

    modport source (output valid, output key_id, output now_seconds, input ready);
    modport sink   (input valid, input key_id, input now_seconds, output ready);
endinterface

interface pkwrl_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            allowed;
    logic [pkwrl_pkg::OUTCOME_W-1:0] outcome;

    modport source (output valid, output allowed, output outcome, input ready);
    modport sink   (input valid, input allowed, input outcome, output ready);
endinterface

[rtl/core/pkwrl_ram.sv]
`timescale 1ns / 1ps
// entry table: one write port, one read port, registered read data
module pkwrl_ram #(
    parameter int DEPTH  = pkwrl_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rd_en,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    output pkwrl_pkg::t_entry      o_rd_data,
    input  logic                   i_wr_en,
    input  logic [ADDR_W-1:0]      i_wr_addr,
    input  pkwrl_pkg::t_entry      i_wr_data
);

    pkwrl_pkg::t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[rtl/core/pkwrl_engine.sv]
`timescale 1ns / 1ps
// engine: table scan for key match and oldest entry, then decision and write-back
module pkwrl_engine #(
    parameter int TABLE_ENTRIES = pkwrl_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W = $clog2(TABLE_ENTRIES),
    parameter int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pkwrl_pkg::KEY_W-1:0]        i_key,
    input  logic [pkwrl_pkg::TIME_W-1:0]       i_now,
    input  logic [pkwrl_pkg::LIMIT_W-1:0]      i_limit,
    input  logic [pkwrl_pkg::WINDOW_W-1:0]     i_window,
    input  logic                               i_slot_free,
    output logic                               o_idle,
    output logic                               o_res_vld,
    output pkwrl_pkg::t_res                    o_res,
    output logic                               o_rd_en,
    output logic [IDX_W-1:0]                   o_rd_addr,
    input  pkwrl_pkg::t_entry                  i_rd_data,
    output logic                               o_wr_en,
    output logic [IDX_W-1:0]                   o_wr_addr,
    output pkwrl_pkg::t_entry                  o_wr_data
);

    pkwrl_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]                  r_used, n_used;
    logic [CNT_W-1:0]                  r_iss;
    logic [IDX_W-1:0]                  r_tag;
    logic                              r_tag_vld;
    logic [pkwrl_pkg::KEY_W-1:0]       r_key;
    logic [pkwrl_pkg::TIME_W-1:0]      r_now;
    logic                              r_found;
    logic [IDX_W-1:0]                  r_hit_idx;
    logic [pkwrl_pkg::COUNT_W-1:0]     r_hit_cnt;
    logic [pkwrl_pkg::TIME_W-1:0]      r_hit_start;
    logic [IDX_W-1:0]                  r_old_idx;
    logic [pkwrl_pkg::TIME_W-1:0]      r_old_start;

    logic                              w_hit;
    logic                              w_scan_done;
    logic                              w_older;
    logic [pkwrl_pkg::TIME_W-1:0]      w_delta;
    logic                              w_expired;
    logic                              w_leave;

    // scan compare on the data returned for tag r_tag
    assign w_hit       = (r_state == pkwrl_pkg::ST_SCAN) && r_tag_vld && (i_rd_data.key == r_key);
    assign w_scan_done = w_hit || ((r_iss >= r_used) && !r_tag_vld);
    assign w_older     = (r_tag == '0) || (i_rd_data.start < r_old_start);

    // window test: signed difference, backwards time stays inside the window
    assign w_delta   = r_now - r_hit_start;
    assign w_expired = !w_delta[pkwrl_pkg::TIME_W-1] &&
                       (w_delta >= pkwrl_pkg::TIME_W'(i_window));
    assign w_leave   = (r_state == pkwrl_pkg::ST_DECIDE) && i_slot_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pkwrl_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = pkwrl_pkg::ST_SCAN;
                end
            end
            pkwrl_pkg::ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = pkwrl_pkg::ST_DECIDE;
                end
            end
            pkwrl_pkg::ST_DECIDE: begin
                if (i_slot_free) begin
                    n_state = pkwrl_pkg::ST_IDLE;
                end
            end
            default: n_state = pkwrl_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_idle    = 1'b0;
        o_rd_en   = 1'b0;
        o_rd_addr = r_iss[IDX_W-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_hit_idx;
        o_wr_data = '{key: r_key, count: pkwrl_pkg::COUNT_W'(1), start: r_now};
        o_res_vld = 1'b0;
        o_res     = '{allowed: 1'b1, outcome: pkwrl_pkg::OUT_COUNTED};
        n_used    = r_used;
        unique case (r_state)
            pkwrl_pkg::ST_IDLE: begin
                o_idle = 1'b1;
            end
            pkwrl_pkg::ST_SCAN: begin
                o_rd_en = (r_iss < r_used) && !w_hit;
            end
            pkwrl_pkg::ST_DECIDE: begin
                o_res_vld = i_slot_free;
                if (r_found) begin
                    if (w_expired) begin
                        o_wr_en     = i_slot_free;
                        o_res       = '{allowed: 1'b1, outcome: pkwrl_pkg::OUT_RESTART};
                    end else if (r_hit_cnt >= i_limit) begin
                        o_res       = '{allowed: 1'b0, outcome: pkwrl_pkg::OUT_REFUSED};
                    end else begin
                        o_wr_en     = i_slot_free;
                        o_wr_data   = '{key: r_key, count: r_hit_cnt + 1'b1, start: r_hit_start};
                        o_res       = '{allowed: 1'b1, outcome: pkwrl_pkg::OUT_COUNTED};
                    end
                end else if (r_used < CNT_W'(TABLE_ENTRIES)) begin
                    o_wr_en   = i_slot_free;
                    o_wr_addr = r_used[IDX_W-1:0];
                    o_res     = '{allowed: 1'b1, outcome: pkwrl_pkg::OUT_NEW};
                    if (i_slot_free) begin
                        n_used = r_used + 1'b1;
                    end
                end else begin
                    o_wr_en   = i_slot_free;
                    o_wr_addr = r_old_idx;
                    o_res     = '{allowed: 1'b1, outcome: pkwrl_pkg::OUT_REPLACED};
                end
            end
            default: o_idle = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pkwrl_pkg::ST_IDLE;
            r_used    <= '0;
            r_tag_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_leave) begin
                r_used <= n_used;
            end
            if (r_state == pkwrl_pkg::ST_IDLE) begin
                r_tag_vld <= 1'b0;
                if (i_start) begin
                    r_found <= 1'b0;
                end
            end else begin
                r_tag_vld <= o_rd_en;
                if (w_hit) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if ((r_state == pkwrl_pkg::ST_IDLE) && i_start) begin
            r_key <= i_key;
            r_now <= i_now;
            r_iss <= '0;
        end else if (o_rd_en) begin
            r_iss <= r_iss + 1'b1;
        end
        if (o_rd_en) begin
            r_tag <= r_iss[IDX_W-1:0];
        end
        if (w_hit) begin
            r_hit_idx   <= r_tag;
            r_hit_cnt   <= i_rd_data.count;
            r_hit_start <= i_rd_data.start;
        end
        if ((r_state == pkwrl_pkg::ST_SCAN) && r_tag_vld && w_older) begin
            r_old_idx   <= r_tag;
            r_old_start <= i_rd_data.start;
        end
    end

endmodule

[rtl/core/per_key_window_rate_limiter.sv]
`timescale 1ns / 1ps
// top level: per-key fixed-window rate limiter with entry table in one memory
// response path: the engine scans entries from index 0 until the key hits or every entry in use,
//   at most TABLE_ENTRIES, has been read, then decides, writes back and fills the response register
// requests: a new one is taken only once the engine has handed over the previous result
// reset: limit 10, window 60 s, table empty (fill count cleared), no clearing pass needed
module per_key_window_rate_limiter #(
    parameter int TABLE_ENTRIES = pkwrl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    pkwrl_req_if.sink                            i_req,
    pkwrl_rsp_if.source                          o_rsp,
    input  logic                                 i_cfg_we,
    input  logic [pkwrl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pkwrl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // table index and fill count widths follow the table size
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // configuration registers
    logic [pkwrl_pkg::LIMIT_W-1:0]  r_limit;
    logic [pkwrl_pkg::WINDOW_W-1:0] r_window;

    // engine to output stage
    logic              w_idle;
    logic              w_res_vld;
    pkwrl_pkg::t_res   w_res;
    logic              w_slot_free;

    // output register parts engine from the response consumer
    logic              r_out_vld;
    pkwrl_pkg::t_res   r_out_res;

    // memory ports
    logic              w_rd_en;
    logic [IDX_W-1:0]  w_rd_addr;
    pkwrl_pkg::t_entry w_rd_data;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    pkwrl_pkg::t_entry w_wr_data;

    // configuration writes, to be made only while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= pkwrl_pkg::RESET_LIMIT;
            r_window <= pkwrl_pkg::RESET_WINDOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pkwrl_pkg::REG_LIMIT:  r_limit  <= i_cfg_data[pkwrl_pkg::LIMIT_W-1:0];
                pkwrl_pkg::REG_WINDOW: r_window <= i_cfg_data[pkwrl_pkg::WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    // a new request is taken whenever the engine is free, even with a response pending
    assign i_req.ready = w_idle;

    // the engine hands over its result only into a free output slot
    assign w_slot_free = !r_out_vld || o_rsp.ready;

    pkwrl_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_req.valid),
        .i_key       (i_req.key_id),
        .i_now       (i_req.now_seconds),
        .i_limit     (r_limit),
        .i_window    (r_window),
        .i_slot_free (w_slot_free),
        .o_idle      (w_idle),
        .o_res_vld   (w_res_vld),
        .o_res       (w_res),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    // key, count and window start of every entry; writes and scan never overlap
    pkwrl_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_vld) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_vld) begin
            r_out_res <= w_res;
        end
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.allowed = r_out_res.allowed;
    assign o_rsp.outcome = r_out_res.outcome;

`ifndef SYNTH
    // an accepted request keeps the engine busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !w_idle)
        else $error("engine idle right after request accept");

    // the engine never overwrites a response that has not been taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_vld |-> w_slot_free)
        else $error("engine result dropped into a full output slot");

    // refused is the only outcome that denies the request
    a_allow_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_vld |-> (w_res.allowed == (w_res.outcome != pkwrl_pkg::OUT_REFUSED)))
        else $error("allowed flag disagrees with outcome code");

    // a response only appears after the engine produced one
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_res_vld))
        else $error("response valid without engine result");
`endif

endmodule

[sim/pkwrl_checker.sv]
`timescale 1ns / 1ps
// checker: watches request, response and config ports, predicts each decision and compares
module pkwrl_checker #(
    parameter int TABLE_ENTRIES = pkwrl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    input  logic                               i_req_ready,
    input  logic [pkwrl_pkg::KEY_W-1:0]        i_req_key,
    input  logic [pkwrl_pkg::TIME_W-1:0]       i_req_now,
    input  logic                               i_rsp_valid,
    input  logic                               i_rsp_ready,
    input  logic                               i_rsp_allowed,
    input  logic [pkwrl_pkg::OUTCOME_W-1:0]    i_rsp_outcome,
    input  logic                               i_cfg_we,
    input  logic [pkwrl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pkwrl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                 o_mismatch_cnt,
    output int                                 o_pending
);

    localparam int REPORT_LIMIT = 10;

    logic [pkwrl_pkg::LIMIT_W-1:0]  limit_q;
    logic [pkwrl_pkg::WINDOW_W-1:0] window_q;
    logic [pkwrl_pkg::KEY_W-1:0]    key_tab   [TABLE_ENTRIES];
    logic [pkwrl_pkg::COUNT_W-1:0]  count_tab [TABLE_ENTRIES];
    logic [pkwrl_pkg::TIME_W-1:0]   start_tab [TABLE_ENTRIES];
    int                             used_q;
    pkwrl_pkg::t_res                verdicts_q [$];
    int                             mismatch_cnt;

    task automatic claim_slot(input int slot, input logic [pkwrl_pkg::KEY_W-1:0] key,
                              input logic [pkwrl_pkg::TIME_W-1:0] now);
        key_tab[slot]   = key;
        count_tab[slot] = pkwrl_pkg::COUNT_W'(1);
        start_tab[slot] = now;
    endtask

    // decision for one request, table updated in place
    task automatic decide_request(input logic [pkwrl_pkg::KEY_W-1:0] key,
                                  input logic [pkwrl_pkg::TIME_W-1:0] now,
                                  output pkwrl_pkg::t_res verdict);
        logic [pkwrl_pkg::TIME_W-1:0] age;
        int                           hit;
        int                           oldest;
        hit     = -1;
        oldest  = 0;
        verdict = '0;
        for (int i = 0; i < used_q; i++) begin
            if (hit < 0 && key_tab[i] == key) hit = i;
        end
        if (hit >= 0) begin
            age = now - start_tab[hit];
            // negative age means time went backwards: still inside the window
            if (!age[pkwrl_pkg::TIME_W-1] && age >= pkwrl_pkg::TIME_W'(window_q)) begin
                claim_slot(hit, key, now);
                verdict.allowed = 1'b1;
                verdict.outcome = pkwrl_pkg::OUT_RESTART;
            end else if (count_tab[hit] >= limit_q) begin
                verdict.allowed = 1'b0;
                verdict.outcome = pkwrl_pkg::OUT_REFUSED;
            end else begin
                count_tab[hit]  = count_tab[hit] + pkwrl_pkg::COUNT_W'(1);
                verdict.allowed = 1'b1;
                verdict.outcome = pkwrl_pkg::OUT_COUNTED;
            end
        end else if (used_q < TABLE_ENTRIES) begin
            claim_slot(used_q, key, now);
            used_q          = used_q + 1;
            verdict.allowed = 1'b1;
            verdict.outcome = pkwrl_pkg::OUT_NEW;
        end else begin
            // full table: oldest window start, unsigned, lowest index on ties
            for (int i = 1; i < TABLE_ENTRIES; i++) begin
                if (start_tab[i] < start_tab[oldest]) oldest = i;
            end
            claim_slot(oldest, key, now);
            verdict.allowed = 1'b1;
            verdict.outcome = pkwrl_pkg::OUT_REPLACED;
        end
    endtask

    always @(posedge i_clk) begin
        pkwrl_pkg::t_res verdict;
        if (!i_rst_n) begin
            limit_q  = pkwrl_pkg::RESET_LIMIT;
            window_q = pkwrl_pkg::RESET_WINDOW;
            used_q   = 0;
            verdicts_q.delete();
            mismatch_cnt = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (verdicts_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("%0t: response with none pending: allowed %0b outcome %0d",
                                 $realtime, i_rsp_allowed, i_rsp_outcome);
                end else begin
                    verdict = verdicts_q.pop_front();
                    if (verdict.allowed !== i_rsp_allowed ||
                        verdict.outcome !== i_rsp_outcome) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT)
                            $display("%0t: mismatch: expected allowed %0b outcome %0d, got %0b %0d",
                                     $realtime, verdict.allowed, verdict.outcome,
                                     i_rsp_allowed, i_rsp_outcome);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                decide_request(i_req_key, i_req_now, verdict);
                verdicts_q.push_back(verdict);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pkwrl_pkg::REG_LIMIT:  limit_q  = i_cfg_data[pkwrl_pkg::LIMIT_W-1:0];
                    pkwrl_pkg::REG_WINDOW: window_q = i_cfg_data[pkwrl_pkg::WINDOW_W-1:0];
                    default: ;
                endcase
            end
        end
        o_mismatch_cnt <= mismatch_cnt;
        o_pending      <= verdicts_q.size();
    end

endmodule

[sim/tb_per_key_window_rate_limiter.sv]
`timescale 1ns / 1ps
// testbench top: clock, reset, request stimulus, config phases and final verdict
module tb_per_key_window_rate_limiter;

    localparam int TABLE_ENTRIES  = pkwrl_pkg::TABLE_ENTRIES_DEF;
    // worst case gap is a full-table miss plus a long receiver stall; this is far above it
    localparam int WATCHDOG_LIMIT = 20000;
    // the drain wait outlasts a miss on a full table, which scans every entry
    localparam int DRAIN_CYCLES   = TABLE_ENTRIES + 8;
    localparam int HOT_KEYS       = 8;
    localparam int PHASE_ITEMS    = 180;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [pkwrl_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [pkwrl_pkg::CFG_DATA_W-1:0] cfg_data;
    int                               mismatch_cnt;
    int                               pending;
    int                               send_idle_pct;
    int                               recv_idle_pct;
    int                               quiet_cycles;

    pkwrl_req_if req_if ();
    pkwrl_rsp_if rsp_if ();

    per_key_window_rate_limiter #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pkwrl_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_if.valid),
        .i_req_ready    (req_if.ready),
        .i_req_key      (req_if.key_id),
        .i_req_now      (req_if.now_seconds),
        .i_rsp_valid    (rsp_if.valid),
        .i_rsp_ready    (rsp_if.ready),
        .i_rsp_allowed  (rsp_if.allowed),
        .i_rsp_outcome  (rsp_if.outcome),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_mismatch_cnt (mismatch_cnt),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // response side backpressure at the current idle rate
    always @(posedge clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("per_key_window_rate_limiter regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one request, with random gaps in front; returns at the accepting edge
    task automatic send_request(input logic [pkwrl_pkg::KEY_W-1:0] key,
                                input logic [pkwrl_pkg::TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.key_id      <= key;
        req_if.now_seconds <= now;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // drop valid, wait for every pending response, then let the block settle
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // both registers, back to back; unused upper bits of the limit write are random
    task automatic write_config(input logic [pkwrl_pkg::LIMIT_W-1:0] limit,
                                input logic [pkwrl_pkg::WINDOW_W-1:0] window);
        cfg_we   <= 1'b1;
        cfg_idx  <= pkwrl_pkg::REG_LIMIT;
        cfg_data <= {8'($urandom), limit};
        @(posedge clk);
        cfg_idx  <= pkwrl_pkg::REG_WINDOW;
        cfg_data <= window;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // one random phase: a burst that runs one key past its limit (unless the window is zero), then mixed traffic
    task automatic run_phase(input int limit, input int window,
                             input logic [pkwrl_pkg::TIME_W-1:0] start);
        logic [pkwrl_pkg::KEY_W-1:0]  hot [HOT_KEYS];
        logic [pkwrl_pkg::KEY_W-1:0]  key;
        logic [pkwrl_pkg::TIME_W-1:0] now;
        int                           pick;
        int                           step;
        wait_idle();
        write_config(pkwrl_pkg::LIMIT_W'(limit), pkwrl_pkg::WINDOW_W'(window));
        foreach (hot[i]) hot[i] = $urandom;
        now = start;
        repeat (limit + 2) send_request(hot[0], now);
        repeat (PHASE_ITEMS) begin
            step = $urandom_range(99);
            if (step < 70)
                now = now + $urandom_range(0, 2);
            else if (step < 85)
                now = now + $urandom_range(0, 2 * window + 1);
            else if (step < 93)
                now = now - $urandom_range(0, window + 5);  // time running backwards
            else
                now = $urandom;
            pick = $urandom_range(99);
            if (pick < 70) begin
                key = hot[$urandom_range(HOT_KEYS - 1)];
            end else if (pick < 75) begin
                // swap a fresh key into the working set
                key = $urandom;
                hot[$urandom_range(HOT_KEYS - 1)] = key;
            end else begin
                // one-off keys fill the table and later force replacement
                key = $urandom;
            end
            send_request(key, now);
        end
    endtask

    initial begin
        logic [pkwrl_pkg::KEY_W-1:0] probe_key;
        logic [pkwrl_pkg::KEY_W-1:0] other_key;
        probe_key = 32'h5A5A_A5A5;
        other_key = 32'h1234_5678;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = pkwrl_pkg::REG_LIMIT;
        cfg_data           = '0;
        req_if.valid       = 1'b0;
        req_if.key_id      = '0;
        req_if.now_seconds = '0;
        rsp_if.ready       = 1'b0;
        quiet_cycles       = 0;
        send_idle_pct      = 25;
        recv_idle_pct      = 74;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: limit 10, window 60
        send_request(32'h0000_0000, 32'h0000_0000);   // new entry
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // new entry at the top of time
        send_request(32'h0000_0000, 32'd5);            // counted
        send_request(32'h0000_0000, 32'd59);           // last second of the window
        send_request(32'h0000_0000, 32'd60);           // window just expired
        send_request(32'hFFFF_FFFF, 32'h0000_0000);   // time wraps, one second later
        send_request(32'h0000_0000, 32'd10);           // time went backwards

        // small limit: run into refusal, then expire
        wait_idle();
        write_config(8'd2, 16'd100);
        send_request(probe_key, 32'd1000);
        send_request(probe_key, 32'd1000);
        send_request(probe_key, 32'd1099);             // at limit, refused
        send_request(probe_key, 32'd1100);             // expired, restarts
        send_request(probe_key, 32'd900);              // backwards, counted

        // limit of zero and window of zero
        wait_idle();
        write_config(8'd0, 16'd0);
        send_request(probe_key, 32'd1100);             // zero age restarts
        send_request(probe_key, 32'd1050);             // backwards, refused at limit zero
        send_request(other_key, 32'd7);                // new entry is allowed anyway
        send_request(other_key, 32'd6);                // refused

        // largest limit and window
        wait_idle();
        write_config(8'd255, 16'hFFFF);
        send_request(probe_key, 32'd1100 + 32'd65534);
        send_request(probe_key, 32'd1100 + 32'd65535);
        send_request(probe_key, 32'h8000_0000 + 32'd1100 + 32'd65535);  // most negative age

        // random traffic: sender-light then receiver-light idling, then none
        run_phase(255, 65535, 32'h0000_1000);
        run_phase(1, 1, 32'hFFFF_FF00);
        send_idle_pct <= 74;
        recv_idle_pct <= 25;
        run_phase(4, 30, $urandom);
        run_phase(0, 0, $urandom);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        run_phase($urandom_range(1, 16), $urandom_range(1, 65535), $urandom);
        run_phase(10, 60, $urandom);

        wait_idle();
        if (mismatch_cnt == 0 && pending == 0) begin
            $display("per_key_window_rate_limiter regression: pass");
        end else begin
            $display("per_key_window_rate_limiter regression: fail");
        end
        $finish;
    end

endmodule
